// File: sv/modular_exponentiation_top_assert.svh
// Assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// same-cycle implication
`define MX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mx_pkg.sv
// Shared constants and types for the modular exponentiation block
`timescale 1ns / 1ps
`default_nettype none

package mx_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

endpackage

`default_nettype wire

// File: sv/modular_exponentiation_top.sv
// Modular exponentiation top level: square-and-multiply over a bit-serial modular multiplier
//
// Computes base_value ** exponent mod modulus. An item is taken when start is high and busy
// is low; the result appears on power_result/bad_modulus for exactly one cycle with done high,
// and the receiver cannot stall it. One shared add-double-reduce unit handles one multiplier
// bit per cycle, MSB first, over all DATA_WIDTH (64) bits of each modular multiply. A zero
// exponent or modulus returns its result in the next cycle; otherwise the block reduces the
// base (ST_REDUCE), then for each exponent bit passes a dispatch state and up to two
// multiplies (ST_MUL_R then ST_MUL_S; the last bit skips the square). An exponent of
// zero returns 1; a zero modulus with a nonzero exponent returns 0 with bad_modulus set.
// The modulus register resets to 1 and may be written only while busy is low.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          modulus_wr,
  input  wire mx_pkg::word_t modulus_data,
  input  wire logic          start,
  output logic               busy,
  input  wire mx_pkg::word_t base_value,
  input  wire mx_pkg::word_t exponent,
  output logic               done,
  output mx_pkg::word_t      power_result,
  output logic               bad_modulus
);

  import mx_pkg::*;

  `include "modular_exponentiation_top_assert.svh"

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_REDUCE   = 3'd1;
  localparam logic [2:0] ST_DISPATCH = 3'd2;
  localparam logic [2:0] ST_MUL_R    = 3'd3;
  localparam logic [2:0] ST_MUL_S    = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  logic [2:0]       state;
  word_t            modulus;
  word_t            acc;
  word_t            mcand;
  word_t            mplier;
  word_t            res;
  word_t            sq;
  word_t            expo;
  logic [CNT_W-1:0] cnt;

  word_t dbl;
  word_t acc_next;
  word_t one_mod;
  logic  accept;
  logic  mul_active;

  // (x + y) mod m for x, y < m
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    logic [DATA_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign one_mod    = (modulus == word_t'(1)) ? '0 : word_t'(1);
  assign mul_active = (state inside {ST_REDUCE, ST_MUL_R, ST_MUL_S});

  always_comb begin
    dbl      = add_mod(acc, acc, modulus);
    acc_next = mplier[DATA_WIDTH-1] ? add_mod(dbl, mcand, modulus) : dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= word_t'(1);
    end else if (modulus_wr) begin
      modulus <= modulus_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= accept && (exponent == '0 || modulus == '0);
          if (accept) begin
            if (exponent == '0) begin
              power_result <= word_t'(1);
              bad_modulus  <= 1'b0;
            end else if (modulus == '0) begin
              power_result <= '0;
              bad_modulus  <= 1'b1;
            end else begin
              res    <= one_mod;
              acc    <= '0;
              mcand  <= one_mod;
              mplier <= base_value;
              expo   <= exponent;
              cnt    <= CNT_LAST;
              state  <= ST_REDUCE;
            end
          end
        end
        ST_DISPATCH: begin
          done <= 1'b0;
          acc  <= '0;
          cnt  <= CNT_LAST;
          if (expo[0]) begin
            mcand  <= res;
            mplier <= sq;
            state  <= ST_MUL_R;
          end else begin
            expo   <= expo >> 1;
            mcand  <= sq;
            mplier <= sq;
            state  <= ST_MUL_S;
          end
        end
        ST_REDUCE, ST_MUL_R, ST_MUL_S: begin
          done <= (state == ST_MUL_R) && (cnt == '0) && (expo[DATA_WIDTH-1:1] == '0);
          if (cnt != '0) begin
            acc    <= acc_next;
            mplier <= mplier << 1;
            cnt    <= cnt - 1'b1;
          end else if (state == ST_MUL_R) begin
            res  <= acc_next;
            expo <= expo >> 1;
            if (expo[DATA_WIDTH-1:1] == '0) begin
              power_result <= acc_next;
              bad_modulus  <= 1'b0;
              state        <= ST_IDLE;
            end else begin
              acc    <= '0;
              cnt    <= CNT_LAST;
              mcand  <= sq;
              mplier <= sq;
              state  <= ST_MUL_S;
            end
          end else begin
            sq    <= acc_next;
            state <= ST_DISPATCH;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MX_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `MX_ASSERT_NOW(a_bad_zero, done && bad_modulus, power_result == '0,
                 "bad modulus with nonzero result")
  `MX_ASSERT_NEXT(a_zero_exp, accept && exponent == '0,
                  done && power_result == word_t'(1) && !bad_modulus,
                  "zero exponent did not return 1")
  `MX_ASSERT_NOW(a_busy_start, $rose(busy), $past(start), "busy rose without start")
  `MX_ASSERT_NOW(a_mul_idle, mul_active, !done, "strobe during multiply")

endmodule

`default_nettype wire
